// File: rtl/lz_flag_word_decompressor_unit_assert.svh
`ifndef LZ_FLAG_WORD_DECOMPRESSOR_UNIT_ASSERT_SVH
`define LZ_FLAG_WORD_DECOMPRESSOR_UNIT_ASSERT_SVH

// checked while out of reset
`define LZFD_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define LZFD_CHK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/lzfd_pkg.sv
package lzfd_pkg;

  localparam int WINDOW_DEPTH   = 16384;
  localparam int WIN_AW         = $clog2(WINDOW_DEPTH);
  localparam int FLAGS_PER_WORD = 30;
  localparam int LEN_SHIFT_BASE = 14;
  localparam int LEN_BIAS       = 3;
  localparam int LEN_W          = 6;

  localparam logic [13:0] OFFSET_MASK_BASE = 14'h3fff;

  typedef logic [WIN_AW-1:0] win_addr_t;

  typedef logic [2:0] phase_t;
  localparam phase_t PH_FLAG0   = 3'd0;
  localparam phase_t PH_FLAG3   = 3'd3;
  localparam phase_t PH_TOKEN   = 3'd4;
  localparam phase_t PH_PAIR_LO = 3'd5;

  typedef enum logic [2:0] {
    ST_IN = 3'b001,
    ST_RD = 3'b010,
    ST_WR = 3'b100
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd_issue;
    logic copy_emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic start_copy;
    logic copy_last;
  } dp_stat_t;

  function automatic win_addr_t win_inc(input win_addr_t ptr);
    win_addr_t res;
    if (ptr == WIN_AW'(WINDOW_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = ptr + 1'b1;
    end
    return res;
  endfunction

endpackage

// File: rtl/lz_flag_word_decompressor_unit.sv
// LZ77 flag-word decompressor. Compressed bytes enter one per word on the in_ channel; each
// group opens with a big-endian 32-bit flag word (30 token flags, MSB first, low two bits set
// the match format), followed by literal bytes and two-byte matches. Decompressed bytes leave
// one per word with run_last on the last byte an input word produced and all_done on the byte
// that reaches out_size; once out_size bytes are out, further input is accepted and dropped.
// Write out_size through cfg_ only while the block is idle. Flag bytes, the first byte of a
// match, dropped bytes and literals are each handled as the input word is taken. On its second
// byte a match copies up to 34 bytes (fewer where out_size cuts it short), each by a window
// RAM read followed by its write-back; a stall on the out_ side holds it. The 16 KiB history
// window needs no clearing after reset: a match must not reach back before the first output
// byte.
module lz_flag_word_decompressor_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_out_size,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_run_last,
  output logic        out_all_done
);

  lzfd_pkg::ctrl_cmd_t cmd;
  lzfd_pkg::dp_stat_t  stat;

  lzfd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  lzfd_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_out_size (cfg_out_size),
    .in_byte      (in_byte),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_byte     (out_byte),
    .out_run_last (out_run_last),
    .out_all_done (out_all_done),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule

// File: rtl/lzfd_ram.sv
module lzfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/lzfd_ctrl.sv
module lzfd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lzfd_pkg::dp_stat_t stat,
  output lzfd_pkg::ctrl_cmd_t cmd
);

  lzfd_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      lzfd_pkg::ST_IN: begin
        in_stall = !stat.out_free;
        if (in_valid && stat.out_free) begin
          cmd.accept = 1'b1;
          if (stat.start_copy) begin
            state_nxt = lzfd_pkg::ST_RD;
          end
        end
      end
      lzfd_pkg::ST_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = lzfd_pkg::ST_WR;
      end
      lzfd_pkg::ST_WR: begin
        if (stat.out_free) begin
          cmd.copy_emit = 1'b1;
          state_nxt     = stat.copy_last ? lzfd_pkg::ST_IN : lzfd_pkg::ST_RD;
        end
      end
      default: begin
        state_nxt = lzfd_pkg::ST_IN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lzfd_pkg::ST_IN;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/lzfd_datapath.sv
module lzfd_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [31:0]         cfg_out_size,
  input  logic [7:0]          in_byte,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [7:0]          out_byte,
  output logic                out_run_last,
  output logic                out_all_done,
  input  lzfd_pkg::ctrl_cmd_t cmd,
  output lzfd_pkg::dp_stat_t  stat
);

  localparam int AW = lzfd_pkg::WIN_AW;
  localparam int LW = lzfd_pkg::LEN_W;

  logic [31:0]         out_size_r, out_size_nxt;
  logic [31:0]         produced_r, produced_nxt;
  logic [31:0]         flag_bits_r, flag_bits_nxt;
  logic [4:0]          flags_left_r, flags_left_nxt;
  logic [1:0]          mode_r, mode_nxt;
  lzfd_pkg::phase_t    phase_r, phase_nxt;
  logic [7:0]          hi_r, hi_nxt;
  lzfd_pkg::win_addr_t wp_r, wp_nxt;
  lzfd_pkg::win_addr_t rp_r, rp_nxt;
  logic [LW-1:0]       len_left_r, len_left_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_byte_r, out_byte_nxt;
  logic                run_last_r, run_last_nxt;
  logic                all_done_r, all_done_nxt;

  logic                done;
  logic [31:0]         room;
  logic [15:0]         pair;
  logic [13:0]         mask;
  logic [3:0]          len_shift;
  logic [15:0]         pair_shifted;
  logic [LW-1:0]       len_full;
  logic [LW-1:0]       len_clamp;
  logic [14:0]         offset;
  logic [AW:0]         wp_ext, off_ext, src_ext;
  logic                lit_emit;
  logic                emit;
  logic                adv_flag;
  logic [7:0]          emit_data;
  logic [7:0]          ram_rdata;

  assign done         = produced_r >= out_size_r;
  assign room         = out_size_r - produced_r;
  assign pair         = {hi_r, in_byte};
  assign mask         = lzfd_pkg::OFFSET_MASK_BASE >> mode_r;
  assign len_shift    = 4'(lzfd_pkg::LEN_SHIFT_BASE) - {2'b00, mode_r};
  assign pair_shifted = pair >> len_shift;
  assign len_full     = {1'b0, pair_shifted[4:0]} + LW'(lzfd_pkg::LEN_BIAS);
  assign len_clamp    = (32'(len_full) > room) ? room[LW-1:0] : len_full;
  assign offset       = {1'b0, pair[13:0] & mask} + 15'd1;

  // window position offset bytes back from the write pointer, wrapped
  assign wp_ext  = {1'b0, wp_r};
  assign off_ext = (AW+1)'(offset);
  assign src_ext = (wp_ext >= off_ext) ? (wp_ext - off_ext)
                 : (wp_ext + (AW+1)'(lzfd_pkg::WINDOW_DEPTH) - off_ext);

  assign lit_emit  = cmd.accept && !done && (phase_r == lzfd_pkg::PH_TOKEN) &&
                     !flag_bits_r[31];
  assign emit      = lit_emit || cmd.copy_emit;
  assign adv_flag  = lit_emit || (cmd.copy_emit && stat.copy_last);
  assign emit_data = lit_emit ? in_byte : ram_rdata;

  assign stat.out_free   = !out_valid_r || !out_stall;
  assign stat.start_copy = !done && (phase_r == lzfd_pkg::PH_PAIR_LO);
  assign stat.copy_last  = (len_left_r == LW'(1));

  lzfd_ram #(
    .WIDTH (8),
    .DEPTH (lzfd_pkg::WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (emit),
    .waddr (wp_r),
    .wdata (emit_data),
    .re    (cmd.rd_issue),
    .raddr (rp_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    out_size_nxt   = out_size_r;
    produced_nxt   = produced_r;
    flag_bits_nxt  = flag_bits_r;
    flags_left_nxt = flags_left_r;
    mode_nxt       = mode_r;
    phase_nxt      = phase_r;
    hi_nxt         = hi_r;
    wp_nxt         = wp_r;
    rp_nxt         = rp_r;
    len_left_nxt   = len_left_r;
    out_valid_nxt  = out_valid_r;
    out_byte_nxt   = out_byte_r;
    run_last_nxt   = run_last_r;
    all_done_nxt   = all_done_r;

    if (cfg_wr_en) begin
      out_size_nxt = cfg_out_size;
    end

    if (cmd.accept && !done) begin
      case (phase_r) inside
        [lzfd_pkg::PH_FLAG0:lzfd_pkg::PH_FLAG3]: begin
          flag_bits_nxt = {flag_bits_r[23:0], in_byte};
          phase_nxt     = phase_r + 3'd1;
          if (phase_r == lzfd_pkg::PH_FLAG3) begin
            flags_left_nxt = 5'(lzfd_pkg::FLAGS_PER_WORD);
            mode_nxt       = in_byte[1:0];
          end
        end
        lzfd_pkg::PH_TOKEN: begin
          if (flag_bits_r[31]) begin
            hi_nxt    = in_byte;
            phase_nxt = lzfd_pkg::PH_PAIR_LO;
          end
        end
        lzfd_pkg::PH_PAIR_LO: begin
          len_left_nxt = len_clamp;
          rp_nxt       = src_ext[AW-1:0];
        end
        default: begin
          phase_nxt = lzfd_pkg::PH_FLAG0;
        end
      endcase
    end

    if (adv_flag) begin
      flag_bits_nxt  = flag_bits_r << 1;
      flags_left_nxt = flags_left_r - 5'd1;
      phase_nxt      = (flags_left_r == 5'd1) ? lzfd_pkg::PH_FLAG0 : lzfd_pkg::PH_TOKEN;
    end

    if (cmd.copy_emit) begin
      rp_nxt       = lzfd_pkg::win_inc(rp_r);
      len_left_nxt = len_left_r - LW'(1);
    end

    if (emit) begin
      wp_nxt        = lzfd_pkg::win_inc(wp_r);
      produced_nxt  = produced_r + 32'd1;
      out_valid_nxt = 1'b1;
      out_byte_nxt  = emit_data;
      run_last_nxt  = lit_emit || stat.copy_last;
      all_done_nxt  = (produced_r + 32'd1) == out_size_r;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_size_r   <= '0;
      produced_r   <= '0;
      flag_bits_r  <= '0;
      flags_left_r <= '0;
      mode_r       <= '0;
      phase_r      <= lzfd_pkg::PH_FLAG0;
      wp_r         <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_size_r   <= out_size_nxt;
      produced_r   <= produced_nxt;
      flag_bits_r  <= flag_bits_nxt;
      flags_left_r <= flags_left_nxt;
      mode_r       <= mode_nxt;
      phase_r      <= phase_nxt;
      wp_r         <= wp_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r       <= hi_nxt;
    rp_r       <= rp_nxt;
    len_left_r <= len_left_nxt;
    out_byte_r <= out_byte_nxt;
    run_last_r <= run_last_nxt;
    all_done_r <= all_done_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_run_last = run_last_r;
  assign out_all_done = all_done_r;

endmodule

// File: rtl/lzfd_checker.sv
`include "lz_flag_word_decompressor_unit_assert.svh"

module lzfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic        out_run_last,
  input logic        out_all_done
);

  // no word left over from before reset
  `LZFD_CHK_RST(a_out_idle_after_rst, !rst_n |=> !out_valid, "word valid after reset")

  // a waiting word holds
  `LZFD_CHK(a_out_hold,
            out_valid && out_stall |=> out_valid && $stable({out_byte, out_run_last, out_all_done}),
            "stalled word changed")

  // input only taken when the output register has room
  `LZFD_CHK(a_in_needs_room, !in_stall && out_valid |-> !out_stall, "input taken while output blocked")

  // a copy in progress holds off the input side
  `LZFD_CHK(a_copy_blocks_in, out_valid && !out_run_last |-> in_stall, "input taken mid-copy")

endmodule

bind lz_flag_word_decompressor_unit lzfd_checker u_lzfd_checker (.*);
